/* hw/rtl/sortq_pkg.sv */
// ----------------------------------------------------------------------------
// sortq_pkg
// Shared types and codes for the sorted priority queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sortq_pkg;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_RESP = 1'b1
    } t_state;

    typedef struct packed {
        logic exec;
        logic func;
    } t_dp_cmd;

endpackage

`default_nettype wire

/* hw/rtl/sortq_ctrl.sv */
// ----------------------------------------------------------------------------
// sortq_ctrl
// Handshake controller: issues one datapath operation per accepted transfer
// and holds the result valid until the receiver takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sortq_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_func,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output sortq_pkg::t_dp_cmd      o_cmd
);
    import sortq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_out_valid = 1'b0;
        o_in_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
            end
            S_RESP: begin
                o_out_valid = 1'b1;
                o_in_ready  = i_out_ready;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
        o_cmd.exec = i_in_valid && o_in_ready;
        o_cmd.func = i_func;
        if (o_cmd.exec) begin
            n_state = S_RESP;
        end else if (r_state == S_RESP && i_out_ready) begin
            n_state = S_IDLE;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/sortq_dp.sv */
// ----------------------------------------------------------------------------
// sortq_dp
// Sorted shift-register store with one compare per cell, the entry count and
// the registered result of the last operation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sortq_dp #(
    parameter int DEPTH    = 16,
    parameter int KEY_BITS = 40,
    parameter int TAG_BITS = 32,
    localparam int CW      = $clog2(DEPTH + 1)
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire sortq_pkg::t_dp_cmd  i_cmd,
    input  wire logic [KEY_BITS-1:0] i_entry_key,
    input  wire logic [TAG_BITS-1:0] i_entry_tag,
    output logic [1:0]               o_status,
    output logic [KEY_BITS-1:0]      o_removed_key,
    output logic [TAG_BITS-1:0]      o_removed_tag,
    output logic [CW-1:0]            o_entry_count,
    output logic                     o_now_empty
);
    import sortq_pkg::*;

    logic [KEY_BITS-1:0] r_key [DEPTH];
    logic [TAG_BITS-1:0] r_tag [DEPTH];
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    t_status             r_status;
    t_status             n_status;
    logic [KEY_BITS-1:0] r_rkey;
    logic [TAG_BITS-1:0] r_rtag;
    logic [DEPTH-1:0]    le;
    logic                full;
    logic                empty;
    logic                do_ins;
    logic                do_rem;

    assign full   = (r_count == CW'(DEPTH));
    assign empty  = (r_count == '0);
    assign do_ins = i_cmd.exec && (i_cmd.func == FUNC_INSERT) && !full;
    assign do_rem = i_cmd.exec && (i_cmd.func == FUNC_REMOVE) && !empty;

    // A cell holds its entry when its key orders at or before the new key.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        assign le[g] = (CW'(g) < r_count) && (r_key[g] <= i_entry_key);

        always_ff @(posedge i_clk) begin
            if (do_ins && !le[g]) begin
                if (g == 0) begin
                    r_key[g] <= i_entry_key;
                    r_tag[g] <= i_entry_tag;
                end else if (le[(g == 0) ? 0 : g - 1]) begin
                    r_key[g] <= i_entry_key;
                    r_tag[g] <= i_entry_tag;
                end else begin
                    r_key[g] <= r_key[(g == 0) ? 0 : g - 1];
                    r_tag[g] <= r_tag[(g == 0) ? 0 : g - 1];
                end
            end else if (do_rem && g < DEPTH - 1) begin
                r_key[g] <= r_key[(g < DEPTH - 1) ? g + 1 : g];
                r_tag[g] <= r_tag[(g < DEPTH - 1) ? g + 1 : g];
            end
        end
    end

    always_comb begin
        n_count  = r_count;
        n_status = ST_INSERTED;
        if (i_cmd.func == FUNC_INSERT) begin
            n_status = full ? ST_FULL : ST_INSERTED;
        end else begin
            n_status = empty ? ST_EMPTY : ST_REMOVED;
        end
        if (do_ins) begin
            n_count = r_count + CW'(1);
        end else if (do_rem) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_rkey   <= do_rem ? r_key[0] : '0;
            r_rtag   <= do_rem ? r_tag[0] : '0;
        end
    end

    assign o_status      = r_status;
    assign o_removed_key = r_rkey;
    assign o_removed_tag = r_rtag;
    assign o_entry_count = r_count;
    assign o_now_empty   = (r_count == '0);

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count exceeds depth");

    a_insert_grows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_ins |=> r_count == $past(r_count) + CW'(1))
        else $error("insert did not grow the count");

    a_idle_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.exec |=> $stable(r_count))
        else $error("count changed without an operation");

    a_remove_sorted : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_rem && r_count > CW'(1)) |-> r_key[0] <= r_key[1])
        else $error("front entries out of key order");

endmodule

`default_nettype wire

/* hw/rtl/sorted_priority_queue_unit.sv */
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Bounded priority queue holding entries sorted by ascending key.
// ----------------------------------------------------------------------------
// Usage: an input transfer carries i_func (insert or remove), i_entry_key and
// i_entry_tag. Each input transfer yields exactly one output transfer with the
// status, the removed key and tag (zero unless an entry was removed), the
// entry count after the operation and an empty flag. Equal keys leave in
// arrival order. An insert on a full queue and a remove on an empty queue
// leave the contents unchanged and are flagged in the status.
// The result is registered at the edge that accepts the input. A new input is
// taken in the same cycle that the pending result is transferred, so the queue
// sustains one operation per cycle while the receiver is ready; every cell
// compares its key with the new key in parallel and shifts in one step.
// When the receiver stalls, the result holds and o_in_ready stays low.
// Reset empties the queue at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue_unit #(
    parameter int DEPTH    = 16,
    parameter int KEY_BITS = 40,
    parameter int TAG_BITS = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_func,
    input  wire logic [KEY_BITS-1:0]           i_entry_key,
    input  wire logic [TAG_BITS-1:0]           i_entry_tag,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [1:0]                         o_status,
    output logic [KEY_BITS-1:0]                o_removed_key,
    output logic [TAG_BITS-1:0]                o_removed_tag,
    output logic [$clog2(DEPTH + 1)-1:0]       o_entry_count,
    output logic                               o_now_empty
);
    import sortq_pkg::*;

    t_dp_cmd cmd;

    sortq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_func),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    sortq_dp #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS),
        .TAG_BITS (TAG_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_entry_key   (i_entry_key),
        .i_entry_tag   (i_entry_tag),
        .o_status      (o_status),
        .o_removed_key (o_removed_key),
        .o_removed_tag (o_removed_tag),
        .o_entry_count (o_entry_count),
        .o_now_empty   (o_now_empty)
    );

endmodule

`default_nettype wire
